[src/lrupr_pkg.sv]
// Shared constants and types for the LRU page replacement block.
`timescale 1ns / 1ps

package lrupr_pkg;

  localparam int FRAMES    = 8;
  localparam int PAGE_BITS = 16;

  // Port widths fixed by the interface.
  localparam int PAGE_W    = 16;
  localparam int FIDX_W    = 3;
  localparam int CFG_W     = 4;
  localparam int CNT_W     = 32;

  localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RANK_W    = IDX_W;

  localparam logic [RANK_W-1:0] RANK_OLDEST = RANK_W'(FRAMES - 1);
  localparam logic [CFG_W-1:0]  RESET_IN_USE = CFG_W'((FRAMES < 8) ? FRAMES : 8);

  typedef struct packed {
    logic capture;  // latch the incoming page
    logic update;   // resolve the reference and commit frame state
  } lrupr_cmd_t;

endpackage

[src/lrupr_ctrl.sv]
// Sequencer for the LRU block: accept, resolve, present result.
`timescale 1ns / 1ps

module lrupr_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output lrupr_pkg::lrupr_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       in_beat;

  // A new beat may land while the last result leaves.
  assign in_ready_o  = (state_q == S_IDLE) || ((state_q == S_OUT) && out_ready_i);
  assign in_beat     = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == S_OUT);

  assign cmd_o.capture = in_beat;
  assign cmd_o.update  = (state_q == S_CALC);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_beat) state_d = S_CALC;
      end
      S_CALC: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (in_beat) state_d = S_CALC;
        else if (out_ready_i) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[src/lrupr_dp.sv]
// Frame table, recency ranks, lookup and replacement datapath.
`timescale 1ns / 1ps

module lrupr_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lrupr_pkg::lrupr_cmd_t           cmd_i,
  input  logic [lrupr_pkg::PAGE_W-1:0]    page_i,
  input  logic                            cfg_valid_i,
  input  logic [lrupr_pkg::CFG_W-1:0]     cfg_data_i,
  output logic                            hit_o,
  output logic [lrupr_pkg::FIDX_W-1:0]    frame_index_o,
  output logic                            evicted_valid_o,
  output logic [lrupr_pkg::PAGE_W-1:0]    evicted_page_o,
  output logic [lrupr_pkg::CNT_W-1:0]     hit_total_o,
  output logic [lrupr_pkg::CNT_W-1:0]     fault_total_o
);

  localparam int NF  = lrupr_pkg::FRAMES;
  localparam int PB  = lrupr_pkg::PAGE_BITS;
  localparam int IW  = lrupr_pkg::IDX_W;
  localparam int RW  = lrupr_pkg::RANK_W;
  localparam int CW  = lrupr_pkg::CNT_W;

  logic [lrupr_pkg::CFG_W-1:0] in_use_q;
  logic [PB-1:0]               pg_q;
  logic [PB-1:0]               page_q [NF];
  logic [NF-1:0]               valid_q, valid_d;
  logic [RW-1:0]               rank_q [NF];
  logic [RW-1:0]               rank_d [NF];
  logic [CW-1:0]               hits_q, hits_d, faults_q, faults_d;

  logic [NF-1:0] active, match;
  logic          hit, have_empty, have_victim;
  logic [IW-1:0] hit_idx, empty_idx, victim_idx, sel_idx;
  logic [RW-1:0] victim_rank, old_rank;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= lrupr_pkg::RESET_IN_USE;
    end else if (cfg_valid_i) begin
      in_use_q <= cfg_data_i;
    end
  end

  // Lanes within the frame count; a count of zero still enables frame 0.
  always_comb begin
    for (int i = 0; i < NF; i++) begin
      active[i] = (i == 0) || (int'(in_use_q) > i);
      match[i]  = active[i] && valid_q[i] && (page_q[i] == pg_q);
    end
  end

  // Lowest match, lowest empty, and oldest valid lane (lowest index on tie).
  always_comb begin
    hit         = 1'b0;
    hit_idx     = '0;
    have_empty  = 1'b0;
    empty_idx   = '0;
    have_victim = 1'b0;
    victim_idx  = '0;
    victim_rank = '0;
    for (int i = 0; i < NF; i++) begin
      if (match[i] && !hit) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
      if (active[i] && !valid_q[i] && !have_empty) begin
        have_empty = 1'b1;
        empty_idx  = IW'(i);
      end
      if (active[i] && valid_q[i] && (!have_victim || rank_q[i] > victim_rank)) begin
        have_victim = 1'b1;
        victim_idx  = IW'(i);
        victim_rank = rank_q[i];
      end
    end
  end

  always_comb begin
    if (hit) begin
      sel_idx  = hit_idx;
      old_rank = rank_q[hit_idx];
    end else if (have_empty) begin
      // Filling an empty frame ages every valid frame, holding at the oldest rank.
      sel_idx  = empty_idx;
      old_rank = lrupr_pkg::RANK_OLDEST;
    end else begin
      sel_idx  = victim_idx;
      old_rank = victim_rank;
    end
  end

  always_comb begin
    valid_d = valid_q;
    for (int i = 0; i < NF; i++) begin
      rank_d[i] = rank_q[i];
      if (IW'(i) == sel_idx) begin
        rank_d[i]  = '0;
        valid_d[i] = 1'b1;
      end else if (valid_q[i] && (rank_q[i] < old_rank)) begin
        rank_d[i] = rank_q[i] + RW'(1);
      end
    end
    hits_d   = hits_q;
    faults_d = faults_q;
    if (hit) begin
      if (hits_q != '1) hits_d = hits_q + CW'(1);
    end else begin
      if (faults_q != '1) faults_d = faults_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      hits_q   <= '0;
      faults_q <= '0;
      for (int i = 0; i < NF; i++) begin
        rank_q[i] <= '0;
      end
    end else if (cmd_i.update) begin
      valid_q  <= valid_d;
      hits_q   <= hits_d;
      faults_q <= faults_d;
      for (int i = 0; i < NF; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  // Payload storage, no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pg_q <= page_i[PB-1:0];
    end
    if (cmd_i.update && !hit) begin
      page_q[sel_idx] <= pg_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      hit_o           <= hit;
      frame_index_o   <= lrupr_pkg::FIDX_W'(sel_idx);
      evicted_valid_o <= !hit && !have_empty;
      evicted_page_o  <= (!hit && !have_empty) ?
                         lrupr_pkg::PAGE_W'(page_q[victim_idx]) : '0;
    end
  end

  assign hit_total_o   = hits_q;
  assign fault_total_o = faults_q;

endmodule

[src/lru_page_replacement.sv]
// LRU page replacement: one page reference in, one hit/fault result out.
// The input beat captures the page, the resolve state updates frame state, and the result is then shown.
// No new reference is taken while one is resolving; the next beat is taken as the result leaves.
// The resolve cycle does the parallel tag compare and the rank scan over all frames.
// Reset: all frames empty, ranks and counters zero, frame count 8; no clearing pass.
`timescale 1ns / 1ps

module lru_page_replacement (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [lrupr_pkg::PAGE_W-1:0]     page_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             hit_o,
  output logic [lrupr_pkg::FIDX_W-1:0]     frame_index_o,
  output logic                             evicted_valid_o,
  output logic [lrupr_pkg::PAGE_W-1:0]     evicted_page_o,
  output logic [lrupr_pkg::CNT_W-1:0]      hit_total_o,
  output logic [lrupr_pkg::CNT_W-1:0]      fault_total_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lrupr_pkg::CFG_W-1:0]      cfg_data_i
);

  lrupr_pkg::lrupr_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  lrupr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd)
  );

  lrupr_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .page_i         (page_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .hit_o          (hit_o),
    .frame_index_o  (frame_index_o),
    .evicted_valid_o(evicted_valid_o),
    .evicted_page_o (evicted_page_o),
    .hit_total_o    (hit_total_o),
    .fault_total_o  (fault_total_o)
  );

  // A hit never evicts.
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && evicted_valid_o))
    else $error("hit result reports an eviction");

  a_evict_page_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !evicted_valid_o) |-> (evicted_page_o == '0))
    else $error("evicted page nonzero without eviction");

  // An accepted beat is resolved before any result is shown.
  a_accept_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !out_valid_o)
    else $error("result shown in the cycle after an input beat");

  // Counters only move in the resolve cycle, never right after a result leaves.
  a_one_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |=> $stable(hit_total_o) && $stable(fault_total_o))
    else $error("counters moved without a resolve cycle");

endmodule
